@@ src/gha_pkg.sv @@
// Package for the generational handle allocator: command and status codes,
// controller state type and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package gha_pkg;

  // Input command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ALLOC    = 2'd0;
  localparam logic [1:0] ST_RELEASED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_REJECT   = 2'd3;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_EXEC = 3'b100
  } gha_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input transaction taken, launch first reads
    logic pop_fetch;  // read slot memory at the popped index
    logic commit;     // write memories, update counters, load result
  } gha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_pending;  // incoming command is an allocate served by the stack
    logic out_free;     // result register can take a new result this cycle
  } gha_sts_t;

endpackage

`default_nettype wire

@@ src/gha_ctrl.sv @@
// Controller state machine for the generational handle allocator.
// Depends on gha_pkg for the state type and command/status structs.
`default_nettype none

module gha_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gha_pkg::gha_sts_t sts,
  output gha_pkg::gha_cmd_t      cmd
);
  import gha_pkg::*;

  gha_state_t state_r;
  gha_state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd.accept    = 1'b0;
    cmd.pop_fetch = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.pop_pending ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        cmd.pop_fetch = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/gha_dpath.sv @@
// Datapath for the generational handle allocator: slot and free-stack
// memories, counters, input capture and the result register.
// Depends on gha_pkg for codes and the command/status structs.
`default_nettype none

module gha_dpath #(
  parameter int SLOT_COUNT = 1024,
  parameter int GEN_BITS   = 16,
  parameter int IDX_W      = $clog2(SLOT_COUNT),
  parameter int CNT_W      = $clog2(SLOT_COUNT + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_command,
  input  wire logic [IDX_W-1:0]     in_handle_index,
  input  wire logic [GEN_BITS-1:0]  in_handle_gen,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_status,
  output logic [IDX_W-1:0]          out_index,
  output logic [GEN_BITS-1:0]       out_gen,
  input  wire gha_pkg::gha_cmd_t    cmd,
  output gha_pkg::gha_sts_t         sts
);
  import gha_pkg::*;

  localparam logic [CNT_W-1:0]    SLOTS_C = CNT_W'(SLOT_COUNT);
  localparam logic [GEN_BITS-1:0] GEN_ONE = {{(GEN_BITS-1){1'b0}}, 1'b1};

  // Slot memory word: alive bit on top of the generation.
  logic [GEN_BITS:0]   slot_mem [SLOT_COUNT];
  logic [IDX_W-1:0]    stack_mem [SLOT_COUNT];

  logic                cmd_r;
  logic [IDX_W-1:0]    idx_r;
  logic [GEN_BITS-1:0] hgen_r;
  logic [CNT_W-1:0]    free_count_r, free_count_nxt;
  logic [CNT_W-1:0]    issued_r, issued_nxt;
  logic [GEN_BITS:0]   slot_q;
  logic [IDX_W-1:0]    stack_q;
  logic                out_valid_r;
  logic [1:0]          out_status_r, status_nxt;
  logic [IDX_W-1:0]    out_index_r, index_nxt;
  logic [GEN_BITS-1:0] out_gen_r, gen_nxt;

  logic [CNT_W-1:0]    stack_top;
  logic [IDX_W-1:0]    slot_ra;
  logic                slot_we;
  logic [IDX_W-1:0]    slot_wa;
  logic [GEN_BITS:0]   slot_wd;
  logic                stack_we;
  logic                slot_alive;
  logic [GEN_BITS-1:0] slot_gen;
  logic [GEN_BITS-1:0] gen_inc;

  assign stack_top       = free_count_r - 1'b1;
  assign sts.pop_pending = (in_command == CMD_ALLOC) && (free_count_r != '0);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_gen    = out_gen_r;

  // Slot read address: the released handle at accept, the popped index after.
  assign slot_ra = cmd.pop_fetch ? stack_q : in_handle_index;

  assign slot_alive = slot_q[GEN_BITS];
  assign slot_gen   = slot_q[GEN_BITS-1:0];
  // Generation advances past its maximum to 1, skipping the invalid value 0.
  assign gen_inc    = (slot_gen == '1) ? GEN_ONE : slot_gen + 1'b1;

  // Decide the result and the memory updates of the pending command.
  always_comb begin
    status_nxt     = ST_FULL;
    index_nxt      = '0;
    gen_nxt        = '0;
    slot_we        = 1'b0;
    slot_wa        = idx_r;
    slot_wd        = '0;
    stack_we       = 1'b0;
    free_count_nxt = free_count_r;
    issued_nxt     = issued_r;
    if (cmd_r == CMD_ALLOC) begin
      if (free_count_r != '0) begin
        // Reuse the most recently freed slot with its current generation.
        status_nxt     = ST_ALLOC;
        index_nxt      = stack_q;
        gen_nxt        = slot_gen;
        slot_we        = 1'b1;
        slot_wa        = stack_q;
        slot_wd        = {1'b1, slot_gen};
        free_count_nxt = stack_top;
      end else if (issued_r < SLOTS_C) begin
        // Hand out a never-used slot with generation 1.
        status_nxt = ST_ALLOC;
        index_nxt  = issued_r[IDX_W-1:0];
        gen_nxt    = GEN_ONE;
        slot_we    = 1'b1;
        slot_wa    = issued_r[IDX_W-1:0];
        slot_wd    = {1'b1, GEN_ONE};
        issued_nxt = issued_r + 1'b1;
      end
    end else begin
      index_nxt = idx_r;
      if ((hgen_r == '0) || ({{(CNT_W-IDX_W){1'b0}}, idx_r} >= issued_r) ||
          !slot_alive || (slot_gen != hgen_r)) begin
        status_nxt = ST_REJECT;
      end else begin
        // Kill the slot, advance its generation and push it for reuse.
        status_nxt = ST_RELEASED;
        slot_we    = 1'b1;
        slot_wd    = {1'b0, gen_inc};
        if (free_count_r < SLOTS_C) begin
          stack_we       = 1'b1;
          free_count_nxt = free_count_r + 1'b1;
        end
      end
    end
  end

  // Slot memory: read in the accept and pop cycles, written at commit.
  always_ff @(posedge clk) begin
    if (cmd.commit && slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (cmd.accept || cmd.pop_fetch) begin
      slot_q <= slot_mem[slot_ra];
    end
  end

  // Free stack memory: top read at accept, push at commit.
  always_ff @(posedge clk) begin
    if (cmd.commit && stack_we) begin
      stack_mem[free_count_r[IDX_W-1:0]] <= idx_r;
    end
    if (cmd.accept) begin
      stack_q <= stack_mem[stack_top[IDX_W-1:0]];
    end
  end

  // Input capture and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_command;
      idx_r  <= in_handle_index;
      hgen_r <= in_handle_gen;
    end
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_index_r  <= index_nxt;
      out_gen_r    <= gen_nxt;
    end
  end

  // Counters and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_count_r <= '0;
      issued_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        free_count_r <= free_count_nxt;
        issued_r     <= issued_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/generational_handle_allocator.sv @@
// Top level of the generational handle allocator: controller plus datapath.
// Depends on gha_pkg, gha_ctrl and gha_dpath.
//
//   Channel  Signals                                         Direction
//   in       in_valid/in_ready, in_command, in_handle_index,  into block
//            in_handle_gen
//   out      out_valid/out_ready, out_status, out_index,      out of block
//            out_gen
//
// A release or a fresh allocate passes through IDLE and EXEC, an allocate
// from the free stack through IDLE, POP and EXEC: the stack read must
// finish before the slot memory can be read at the popped index. A slot
// change ends with a write of the single-port slot memory. Reset clears
// the state, counters and result valid only; no memory clearing pass is
// needed. A new transaction is accepted while a result waits; if the
// result register is still full, EXEC waits for out_ready before commit.
`default_nettype none

module generational_handle_allocator #(
  parameter int SLOT_COUNT = 1024,
  parameter int GEN_BITS   = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_command,
  input  wire logic [$clog2(SLOT_COUNT)-1:0]   in_handle_index,
  input  wire logic [GEN_BITS-1:0]             in_handle_gen,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_status,
  output logic [$clog2(SLOT_COUNT)-1:0]        out_index,
  output logic [GEN_BITS-1:0]                  out_gen
);
  import gha_pkg::*;

  gha_cmd_t cmd;
  gha_sts_t sts;

  // Sequencing of each transaction.
  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memories, counters and result register.
  gha_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_BITS   (GEN_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_handle_index (in_handle_index),
    .in_handle_gen   (in_handle_gen),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_index       (out_index),
    .out_gen         (out_gen),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire
